[sv/char_lcd_nibble_bus_writer_macros.svh]
// Assertion macros used by the character display writer checker.
`ifndef CHAR_LCD_NIBBLE_BUS_WRITER_MACROS_SVH
`define CHAR_LCD_NIBBLE_BUS_WRITER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CLCD_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CLCD_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/clcd_pkg.sv]
// Types and constants of the character display nibble bus writer.
`timescale 1ns / 1ps
package clcd_pkg;

	// Display commands and special characters
	localparam logic [7:0] CMD_LINE2 = 8'hC0;
	localparam logic [7:0] CMD_HOME  = 8'h80;
	localparam logic [7:0] NL_CODE   = 8'd10;
	localparam logic [7:0] NUL_CODE  = 8'd0;

	// Bus byte layout
	localparam int EN_POS = 2;

	// Six bus bytes per display byte: three per nibble
	localparam int PHASE_W = 3;
	localparam logic [PHASE_W-1:0] PH_HI_EN   = 3'd1;
	localparam logic [PHASE_W-1:0] PH_HI_LAST = 3'd2;
	localparam logic [PHASE_W-1:0] PH_LO_EN   = 3'd4;
	localparam logic [PHASE_W-1:0] PH_LAST    = 3'd5;

	// One classified item: a first display byte and an optional data byte
	typedef struct packed {
		logic [7:0] first_byte;
		logic       first_rs;
		logic       two;
		logic [7:0] second_byte;
	} job_t;

	// Queue status seen by the front and back parts
	typedef struct packed {
		logic full;
		logic valid;
	} qstat_t;

endpackage

[sv/clcd_front.sv]
// Front part: accepts characters, tracks the cursor, classifies into jobs.
`timescale 1ns / 1ps
module clcd_front #(
	parameter int LINE_LENGTH = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  logic [7:0]          char_code,
	input  logic                string_start,
	input  clcd_pkg::qstat_t    qstat,
	output logic                job_push,
	output clcd_pkg::job_t      job
);
	import clcd_pkg::*;

	localparam int POS_W = $clog2(2 * LINE_LENGTH + 1);
	localparam logic [POS_W-1:0] POS_L  = POS_W'(LINE_LENGTH);
	localparam logic [POS_W-1:0] POS_2L = POS_W'(2 * LINE_LENGTH);

	logic [POS_W-1:0] cursor_q;
	logic [POS_W-1:0] pos0;
	logic [POS_W-1:0] pos_nxt;
	logic             accept;

	assign accept = push && !qstat.full;
	assign pos0   = string_start ? '0 : cursor_q;

	// Classify the character and work out the next cursor position
	always_comb begin
		job.first_byte  = char_code;
		job.first_rs    = 1'b1;
		job.two         = 1'b0;
		job.second_byte = char_code;
		job_push        = 1'b0;
		pos_nxt         = pos0;
		if (char_code == NUL_CODE) begin
			job_push = 1'b0;
		end else if (char_code == NL_CODE) begin
			job_push = accept;
			job.first_rs = 1'b0;
			if (pos0 <= POS_L) begin
				job.first_byte = CMD_LINE2;
				pos_nxt        = POS_L;
			end else begin
				job.first_byte = CMD_HOME;
				pos_nxt        = '0;
			end
		end else begin
			job_push = accept;
			pos_nxt  = pos0 + 1'b1;
			if (pos0 == POS_L) begin
				job.first_byte = CMD_LINE2;
				job.first_rs   = 1'b0;
				job.two        = 1'b1;
			end else if (pos0 == POS_2L) begin
				job.first_byte = CMD_HOME;
				job.first_rs   = 1'b0;
				job.two        = 1'b1;
				pos_nxt        = POS_W'(1);
			end
		end
	end

	// Hold the cursor between items
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q <= '0;
		end else if (accept) begin
			cursor_q <= pos_nxt;
		end
	end

endmodule

[sv/clcd_fifo.sv]
// Two-entry job queue between the front and back parts.
`timescale 1ns / 1ps
module clcd_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr,
	input  clcd_pkg::job_t   wr_job,
	input  logic             rd,
	output clcd_pkg::job_t   rd_job,
	output clcd_pkg::qstat_t qstat
);
	import clcd_pkg::*;

	job_t       slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       do_wr;
	logic       do_rd;

	assign qstat.full  = (cnt_q == 2'd2);
	assign qstat.valid = (cnt_q != 2'd0);
	assign do_wr       = wr && !qstat.full;
	assign do_rd       = rd && qstat.valid;
	assign rd_job      = slot_q[rd_ptr_q];

	// Store entries
	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wr_ptr_q] <= wr_job;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_rd) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({do_wr, do_rd})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

[sv/clcd_back.sv]
// Back part: expands each job into nibble bus bytes, one per cycle while a job waits and the result is taken.
`timescale 1ns / 1ps
module clcd_back (
	input  logic             clk,
	input  logic             arst_n,
	input  clcd_pkg::job_t   job,
	input  clcd_pkg::qstat_t qstat,
	output logic             job_pop,
	output logic             empty,
	input  logic             pop,
	output logic [7:0]       bus_byte,
	output logic             last
);
	import clcd_pkg::*;

	logic [PHASE_W-1:0] phase_q;
	logic               byte_idx_q;
	logic               out_valid_q;
	logic [7:0]         bus_byte_q;
	logic               last_q;
	logic               adv;
	logic               fin;
	logic [7:0]         cur_byte;
	logic               cur_rs;
	logic [3:0]         nib;
	logic               en;
	logic [7:0]         nxt_byte;

	assign empty    = !out_valid_q;
	assign bus_byte = bus_byte_q;
	assign last     = last_q;

	// Build the bus byte for the current step
	always_comb begin
		cur_byte = byte_idx_q ? job.second_byte : job.first_byte;
		cur_rs   = byte_idx_q ? 1'b1 : job.first_rs;
		nib      = (phase_q <= PH_HI_LAST) ? cur_byte[7:4] : cur_byte[3:0];
		en       = (phase_q == PH_HI_EN) || (phase_q == PH_LO_EN);
		nxt_byte = {nib, 3'b000, cur_rs};
		nxt_byte[EN_POS] = en;
		fin      = (phase_q == PH_LAST) && (byte_idx_q || !job.two);
	end

	assign adv     = qstat.valid && (!out_valid_q || pop);
	assign job_pop = adv && fin;

	// Advance the step counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= '0;
			byte_idx_q <= 1'b0;
		end else if (adv) begin
			if (fin) begin
				phase_q    <= '0;
				byte_idx_q <= 1'b0;
			end else if (phase_q == PH_LAST) begin
				phase_q    <= '0;
				byte_idx_q <= 1'b1;
			end else begin
				phase_q <= phase_q + 1'b1;
			end
		end
	end

	// Hold the result until it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			bus_byte_q <= nxt_byte;
			last_q     <= fin;
		end
	end

endmodule

[sv/char_lcd_nibble_bus_writer.sv]
// Top level of the character display nibble bus writer.
//
//  channel  | handshake     | payload
//  ---------+---------------+---------------------------
//  input    | push / full   | char_code[7:0], string_start
//  result   | empty / pop   | bus_byte[7:0], last
//
// One bus byte leaves per cycle from the back part's step counter while a job
// waits and the result is taken; six bytes per character or newline, twelve at line end.
// A two-entry job queue lets the front take new characters while the back
// still expands earlier ones; a zero character is accepted but gives no output.
// Reset (arst_n low) clears the cursor, the queue, the step counters and the output valid flag.
// A stalled result holds the back part; the front stalls only on a full queue.
`timescale 1ns / 1ps
module char_lcd_nibble_bus_writer #(
	parameter int LINE_LENGTH = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] char_code,
	input  logic       string_start,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] bus_byte,
	output logic       last
);
	import clcd_pkg::*;

	qstat_t qstat;
	job_t   wr_job;
	job_t   rd_job;
	logic   job_push;
	logic   job_pop;

	assign full = qstat.full;

	clcd_front #(
		.LINE_LENGTH(LINE_LENGTH)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.char_code   (char_code),
		.string_start(string_start),
		.qstat       (qstat),
		.job_push    (job_push),
		.job         (wr_job)
	);

	clcd_fifo u_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.wr    (job_push),
		.wr_job(wr_job),
		.rd    (job_pop),
		.rd_job(rd_job),
		.qstat (qstat)
	);

	clcd_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.job     (rd_job),
		.qstat   (qstat),
		.job_pop (job_pop),
		.empty   (empty),
		.pop     (pop),
		.bus_byte(bus_byte),
		.last    (last)
	);

endmodule

[sv/clcd_checker.sv]
// Port-level checker for the character display writer, with its bind.
`timescale 1ns / 1ps
`include "char_lcd_nibble_bus_writer_macros.svh"
module clcd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       empty,
	input logic       pop,
	input logic [7:0] bus_byte,
	input logic       last
);

	// A waiting result holds until taken
	`CLCD_ASSERT_NXT(a_hold, !empty && !pop, !empty && $stable(bus_byte) && $stable(last), "result changed while stalled")

	// Unused bus bits stay low
	`CLCD_ASSERT_IMP(a_zero_bits, !empty, !bus_byte[1] && !bus_byte[3], "bus byte bits 1 or 3 set")

	// The final byte of a character never carries the enable strobe
	`CLCD_ASSERT_IMP(a_last_no_en, !empty && last, !bus_byte[2], "enable set on last byte")

	// An enable strobe is followed at once by the same nibble with enable low
	`CLCD_ASSERT_NXT(a_en_fall, !empty && pop && bus_byte[2], !empty && !bus_byte[2] && bus_byte[7:4] == $past(bus_byte[7:4]) && bus_byte[0] == $past(bus_byte[0]), "enable pulse not closed")

endmodule

bind char_lcd_nibble_bus_writer clcd_checker u_clcd_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.empty   (empty),
	.pop     (pop),
	.bus_byte(bus_byte),
	.last    (last)
);

[tb/tb.sv]
// Self-checking testbench for the character display nibble bus writer.
`timescale 1ns / 1ps
module tb;
	import clcd_pkg::*;

	localparam int LINE_LEN = 16;
	localparam int RANDOM_CHARS = 290;
	localparam int HOLD_CYCLES = 250;
	localparam int MAX_REPORTS = 10;

	// One bus byte as it leaves the block
	typedef struct packed {
		logic [7:0] bus;
		logic       last;
	} lcd_bus_t;

	// Directed row: typed rows carry their own leading command and data flag
	typedef struct packed {
		logic [7:0] code;
		logic       start;
		logic       typed;
		logic [7:0] lead;
		logic       with_char;
	} lcd_row_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       push = 1'b0;
	logic       pop = 1'b0;
	logic [7:0] char_code = 8'd0;
	logic       string_start = 1'b0;
	logic       full;
	logic       empty;
	logic [7:0] bus_byte;
	logic       last;

	lcd_bus_t   bus_expect [$];
	lcd_bus_t   char_bytes [$];
	lcd_row_t   directed_rows [$];
	logic [7:0] cursor;
	int         items_in = 0;
	int         fail_count = 0;
	int         bytes_checked = 0;
	int         stall_cycles = 0;
	int         n_chars = 0;
	int         n_newlines = 0;
	int         n_nuls = 0;
	int         n_line2_wraps = 0;
	int         n_home_wraps = 0;
	logic       quiet;

	char_lcd_nibble_bus_writer #(
		.LINE_LENGTH(LINE_LEN)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.char_code(char_code),
		.string_start(string_start),
		.empty(empty),
		.pop(pop),
		.bus_byte(bus_byte),
		.last(last)
	);

	always #5 clk = ~clk;

	// Stretch of items with no idling on either side
	assign quiet = (items_in >= 150) && (items_in < 230);

	function automatic void flag_fail(input string what);
		fail_count++;
		if (fail_count <= MAX_REPORTS)
			$display("ERROR at %0t ns: %s", $time, what);
	endfunction

	// Append the six bus bytes of one display byte, moving the last mark
	function automatic void add_display(input logic [7:0] b, input logic rs);
		logic [7:0] base;
		lcd_bus_t   nb;
		if (char_bytes.size() != 0)
			char_bytes[char_bytes.size() - 1].last = 1'b0;
		for (int h = 1; h >= 0; h--) begin
			base = {b[h*4 +: 4], 3'b000, rs};
			nb.last = 1'b0;
			nb.bus = base;
			char_bytes.push_back(nb);
			nb.bus = base | (8'd1 << EN_POS);
			char_bytes.push_back(nb);
			nb.bus = base;
			nb.last = (h == 0);
			char_bytes.push_back(nb);
		end
	endfunction

	// Work out the bus bytes of one character and advance the cursor
	function automatic void predict_bus_bytes(input logic [7:0] c, input logic s);
		char_bytes.delete();
		if (s)
			cursor = 8'd0;
		if (c == NUL_CODE) begin
			n_nuls++;
		end else if (c == NL_CODE) begin
			n_newlines++;
			if (cursor <= LINE_LEN) begin
				add_display(CMD_LINE2, 1'b0);
				cursor = 8'(LINE_LEN);
			end else begin
				add_display(CMD_HOME, 1'b0);
				cursor = 8'd0;
			end
		end else begin
			n_chars++;
			if (cursor == LINE_LEN) begin
				add_display(CMD_LINE2, 1'b0);
				n_line2_wraps++;
			end
			if (cursor == 2 * LINE_LEN) begin
				add_display(CMD_HOME, 1'b0);
				cursor = 8'd0;
				n_home_wraps++;
			end
			add_display(c, 1'b1);
			if (cursor != 8'd255)
				cursor++;
		end
	endfunction

	// Offer one item until the block takes it, then queue its bus bytes
	task automatic offer_char(input logic [7:0] c, input logic s, input logic typed,
			input logic [7:0] lead, input logic with_char);
		while (!quiet && $urandom_range(99) < 9) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		char_code <= c;
		string_start <= s;
		@(posedge clk);
		while (full) begin
			stall_cycles++;
			@(posedge clk);
		end
		items_in++;
		predict_bus_bytes(c, s);
		// Typed rows replace the prediction with the values written in the table
		if (typed) begin
			char_bytes.delete();
			if (lead != NUL_CODE)
				add_display(lead, 1'b0);
			if (with_char)
				add_display(c, 1'b1);
		end
		foreach (char_bytes[i])
			bus_expect.push_back(char_bytes[i]);
	endtask

	// Receiver: check each popped byte and decide pop for the next cycle
	initial begin
		lcd_bus_t exp_b;
		int       hold_left;
		bit       hold_done;
		hold_left = 0;
		hold_done = 1'b0;
		forever begin
			@(posedge clk);
			if (pop && !empty) begin
				if (bus_expect.size() == 0) begin
					flag_fail($sformatf("unexpected bus byte %02h last %0b", bus_byte, last));
				end else begin
					exp_b = bus_expect.pop_front();
					bytes_checked++;
					if (bus_byte !== exp_b.bus || last !== exp_b.last)
						flag_fail($sformatf("bus byte %02h last %0b, expected %02h last %0b",
							bus_byte, last, exp_b.bus, exp_b.last));
				end
			end
			// Hold off once for a long stretch so the block fills up
			if (!hold_done && items_in >= 60) begin
				hold_left = HOLD_CYCLES;
				hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else if (!quiet && $urandom_range(99) < 9) begin
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	// Stimulus and end of run
	initial begin
		logic [7:0] c;
		logic       s;
		int         sent_random;
		int         str_len;
		int         pick;
		cursor = 8'd0;
		sent_random = 0;
		directed_rows = '{
			'{8'h41, 1'b1, 1'b1, NUL_CODE, 1'b1},
			'{8'hFF, 1'b0, 1'b1, NUL_CODE, 1'b1},
			'{NUL_CODE, 1'b0, 1'b1, NUL_CODE, 1'b0},
			'{NL_CODE, 1'b0, 1'b1, CMD_LINE2, 1'b0},
			'{8'h01, 1'b0, 1'b1, CMD_LINE2, 1'b1},
			'{NL_CODE, 1'b0, 1'b1, CMD_HOME, 1'b0},
			'{NUL_CODE, 1'b1, 1'b1, NUL_CODE, 1'b0},
			'{NL_CODE, 1'b1, 1'b1, CMD_LINE2, 1'b0},
			'{NL_CODE, 1'b0, 1'b1, CMD_LINE2, 1'b0},
			'{8'h7F, 1'b0, 1'b0, NUL_CODE, 1'b0},
			'{8'h0B, 1'b0, 1'b0, NUL_CODE, 1'b0},
			'{8'h80, 1'b0, 1'b0, NUL_CODE, 1'b0},
			'{8'hC0, 1'b0, 1'b0, NUL_CODE, 1'b0},
			'{8'hFE, 1'b0, 1'b0, NUL_CODE, 1'b0},
			'{8'h09, 1'b0, 1'b0, NUL_CODE, 1'b0},
			'{8'h0F, 1'b0, 1'b0, NUL_CODE, 1'b0},
			'{8'hF0, 1'b0, 1'b0, NUL_CODE, 1'b0},
			'{8'h55, 1'b0, 1'b0, NUL_CODE, 1'b0},
			'{8'hAA, 1'b0, 1'b0, NUL_CODE, 1'b0},
			'{8'h20, 1'b0, 1'b0, NUL_CODE, 1'b0},
			'{8'h7E, 1'b0, 1'b0, NUL_CODE, 1'b0},
			'{8'h11, 1'b0, 1'b0, NUL_CODE, 1'b0},
			'{8'hEE, 1'b0, 1'b0, NUL_CODE, 1'b0},
			'{8'h33, 1'b0, 1'b0, NUL_CODE, 1'b0},
			'{8'hCC, 1'b0, 1'b0, NUL_CODE, 1'b0},
			'{8'h20, 1'b0, 1'b1, CMD_HOME, 1'b1}
		};

		// Hold reset, then release it at a clock edge
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed rows: extremes, newline both ways, zero character, both wraps
		foreach (directed_rows[i])
			offer_char(directed_rows[i].code, directed_rows[i].start,
				directed_rows[i].typed, directed_rows[i].lead,
				directed_rows[i].with_char);

		// Random strings: runs of random codes, mostly characters, long enough to reach both wraps
		while (sent_random < RANDOM_CHARS) begin
			str_len = $urandom_range(45, 1);
			for (int k = 0; k < str_len && sent_random < RANDOM_CHARS; k++) begin
				s = (k == 0) ? 1'b1 : ($urandom_range(99) < 2);
				pick = $urandom_range(99);
				if (pick < 3) begin
					c = NUL_CODE;
				end else if (pick < 7) begin
					c = NL_CODE;
				end else begin
					c = 8'($urandom_range(254, 1));
					if (c >= NL_CODE)
						c = c + 8'd1;
				end
				offer_char(c, s, 1'b0, NUL_CODE, 1'b0);
				if (c != NUL_CODE)
					sent_random++;
			end
			// Close some strings with a zero character
			if ($urandom_range(99) < 30)
				offer_char(NUL_CODE, 1'b0, 1'b0, NUL_CODE, 1'b0);
		end
		push <= 1'b0;

		// Drain, then let the pipeline settle
		while (bus_expect.size() != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
		if (bus_expect.size() != 0)
			flag_fail($sformatf("%0d bus bytes never arrived", bus_expect.size()));

		$display("Sent %0d items: %0d characters, %0d newlines, %0d zero characters",
			items_in, n_chars, n_newlines, n_nuls);
		$display("Line 2 wraps %0d, home wraps %0d, %0d bus bytes checked, %0d full stalls",
			n_line2_wraps, n_home_wraps, bytes_checked, stall_cycles);
		if (fail_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Mismatches: %0d", fail_count);
			$display("Test completed with failures");
		end
		$finish;
	end

	// Stop a hung run
	initial begin
		#2000000;
		$display("Timeout after %0t ns", $time);
		$display("Test completed with failures");
		$finish;
	end

endmodule
